>>> src/swrl_pkg.sv
// Package for the sliding window rate limiter: widths, register indexes,
// reset values, controller states and the divider request/response types.
// No dependencies.
package swrl_pkg;

  // Default ring size
  localparam int MAX_SLOTS_DEF = 16;

  // Field widths
  localparam int TIME_W     = 48;
  localparam int CNT_W      = 16;
  localparam int SPLIT_W    = 5;
  localparam int SUM_W      = 21;  // up to 31 counters of 16 bits
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int STEPS_W    = 6;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REQUEST_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_NUM     = 2'd2;

  // Register reset values
  localparam logic [CNT_W-1:0]   WINDOW_MS_RST     = 16'd1000;
  localparam logic [CNT_W-1:0]   REQUEST_LIMIT_RST = 16'd100;
  localparam logic [SPLIT_W-1:0] SPLIT_NUM_RST     = 5'd10;

  // Divider step counts: slot width (16-bit dividend), slot count (48-bit)
  localparam logic [STEPS_W-1:0] STEPS_WIDTH = 6'd16;
  localparam logic [STEPS_W-1:0] STEPS_TIME  = 6'd48;

  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_DIVW,
    ST_DIVE,
    ST_CLEAR,
    ST_SUM,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic               start;
    logic [TIME_W-1:0]  dividend;
    logic [CNT_W-1:0]   divisor;
    logic [STEPS_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] quotient;
    logic [CNT_W-1:0]  remainder;
  } div_rsp_t;

endpackage

>>> src/swrl_if.sv
// Handshake channels of the rate limiter: request, result and
// configuration write. Depends on swrl_pkg.
interface swrl_req_if;
  logic                        valid;
  logic                        ready;
  logic [swrl_pkg::TIME_W-1:0] now_ms;
  modport source (output valid, output now_ms, input ready);
  modport sink (input valid, input now_ms, output ready);
endinterface

interface swrl_res_if;
  logic                       valid;
  logic                       ready;
  logic                       granted;
  logic [swrl_pkg::CNT_W-1:0] window_count;
  modport source (output valid, output granted, output window_count, input ready);
  modport sink (input valid, input granted, input window_count, output ready);
endinterface

interface swrl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [swrl_pkg::CFG_IDX_W-1:0]  index;
  logic [swrl_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/swrl_div.sv
// Restoring divider, one quotient bit per cycle, 48-bit dividend by
// 16-bit divisor. Depends on swrl_pkg.
module swrl_div (
  input  logic               clk,
  input  logic               rst,
  input  swrl_pkg::div_req_t req,
  output swrl_pkg::div_rsp_t rsp
);

  logic [swrl_pkg::TIME_W-1:0]  quo;
  logic [swrl_pkg::CNT_W-1:0]   rem;
  logic [swrl_pkg::CNT_W-1:0]   dsr;
  logic [swrl_pkg::STEPS_W-1:0] cnt;
  logic                         busy;
  logic                         done;
  logic [swrl_pkg::CNT_W:0]     shifted;
  logic                         take;
  logic [swrl_pkg::CNT_W-1:0]   rem_next;

  // One trial subtraction
  always_comb begin
    shifted  = {rem, quo[swrl_pkg::TIME_W-1]};
    take     = shifted >= {1'b0, dsr};
    rem_next = take ? swrl_pkg::CNT_W'(shifted - {1'b0, dsr})
                    : swrl_pkg::CNT_W'(shifted);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= '0;
        quo  <= req.dividend;
        dsr  <= req.divisor;
        cnt  <= req.steps;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[swrl_pkg::TIME_W-2:0], take};
        cnt <= cnt - 1'b1;
        if (cnt == swrl_pkg::STEPS_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

>>> src/swrl_slot_mem.sv
// Slot counter memory: one write port, one registered read port, and a
// valid bit per entry so that entries never written read as zero.
// Depends on swrl_pkg.
module swrl_slot_mem #(
  parameter int DEPTH = swrl_pkg::MAX_SLOTS_DEF,
  parameter int AW    = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [swrl_pkg::CNT_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [swrl_pkg::CNT_W-1:0] rdata
);

  logic [swrl_pkg::CNT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           vld;
  logic [swrl_pkg::CNT_W-1:0] rd_q;
  logic                       rd_vld_q;

  // Storage
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  // Written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (re) begin
        rd_vld_q <= vld[raddr];
      end
    end
  end

  assign rdata = rd_vld_q ? rd_q : '0;

endmodule

>>> src/sliding_window_rate_limiter_top.sv
// Sliding window rate limiter: a request takes one pass of the controller
// through the divider and the slot memory, and then one result word is
// produced. Depends on swrl_pkg, swrl_if, swrl_div and swrl_slot_mem.
//
// Each request word carries its timestamp in ms and yields one result word
// (granted, count in window before the decision). The block takes one
// request at a time. The time a request takes is set by the bit-serial
// divider, which runs 16 steps for the slot width and 48 steps for the
// elapsed slots, by the clearing of the slots retired by that request
// (at most N, the number of slots in use), and by the single read port
// of the slot memory, which is swept once per request to form the sum.
// After split_num is lowered, the first request reduces the ring index
// by N in each pass through the MOD state until it lies below N. The next
// request is taken while a result waits in the output register. Registers
// may be written only when no request is in progress.
module sliding_window_rate_limiter_top #(
  parameter int MAX_SLOTS = swrl_pkg::MAX_SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  swrl_req_if.sink   req,
  swrl_res_if.source res,
  swrl_cfg_if.sink   cfg
);

  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = IW + 1;

  swrl_pkg::state_t state;
  swrl_pkg::state_t state_next;

  // Configuration
  logic [swrl_pkg::CNT_W-1:0]   window_ms;
  logic [swrl_pkg::CNT_W-1:0]   request_limit;
  logic [swrl_pkg::SPLIT_W-1:0] split_num;

  // Per-request state
  logic [swrl_pkg::TIME_W-1:0] now_q;
  logic [swrl_pkg::TIME_W-1:0] start_ms;
  logic [IW-1:0]               idx;
  logic [CW-1:0]               clr_cnt;
  logic [CW-1:0]               rd_ptr;
  logic                        rd_vld;
  logic [IW-1:0]               rd_addr;
  logic [swrl_pkg::SUM_W-1:0]  sum;
  logic [swrl_pkg::CNT_W-1:0]  own;

  // Output register
  logic                       res_valid;
  logic                       res_granted;
  logic [swrl_pkg::CNT_W-1:0] res_count;

  // Derived values
  logic [CW-1:0]               n_use;
  logic [CW-1:0]               idx_ext;
  logic [CW-1:0]               idx_inc;
  logic [IW-1:0]               idx_wrap;
  logic [swrl_pkg::TIME_W-1:0] elapsed;
  logic [swrl_pkg::CNT_W-1:0]  width_calc;
  logic [CW-1:0]               slide;
  logic                        grant;
  logic [swrl_pkg::CNT_W-1:0]  sum_sat;
  logic                        out_free;

  // Divider and memory connections
  swrl_pkg::div_req_t         div_req;
  swrl_pkg::div_rsp_t         div_rsp;
  logic                       mem_we;
  logic [IW-1:0]              mem_waddr;
  logic [swrl_pkg::CNT_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [swrl_pkg::CNT_W-1:0] mem_rdata;

  swrl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  swrl_slot_mem #(
    .DEPTH (MAX_SLOTS),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_ptr[IW-1:0]),
    .rdata (mem_rdata)
  );

  // Slot count in use, clamped to 1..MAX_SLOTS
  always_comb begin
    if (split_num == '0) begin
      n_use = CW'(1);
    end else if (32'(split_num) > MAX_SLOTS) begin
      n_use = CW'(MAX_SLOTS);
    end else begin
      n_use = CW'(split_num);
    end
  end

  // Ring step, elapsed time, slide length, decision
  always_comb begin
    idx_ext    = {1'b0, idx};
    idx_inc    = idx_ext + CW'(1);
    idx_wrap   = (idx_inc == n_use) ? '0 : idx_inc[IW-1:0];
    elapsed    = (now_q > start_ms) ? (now_q - start_ms) : '0;
    width_calc = (div_rsp.quotient[swrl_pkg::CNT_W-1:0] == '0) ? swrl_pkg::CNT_W'(1)
                 : div_rsp.quotient[swrl_pkg::CNT_W-1:0];
    slide      = (div_rsp.quotient < swrl_pkg::TIME_W'(n_use))
                 ? CW'(div_rsp.quotient) : n_use;
    grant      = sum < swrl_pkg::SUM_W'(request_limit);
    sum_sat    = (sum > swrl_pkg::SUM_W'(swrl_pkg::CNT_MAX)) ? swrl_pkg::CNT_MAX
                 : sum[swrl_pkg::CNT_W-1:0];
    out_free   = !res_valid || res.ready;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swrl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, divider launches and memory accesses
  always_comb begin
    state_next = state;
    div_req    = '0;
    mem_we     = 1'b0;
    mem_waddr  = idx;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    case (state)
      swrl_pkg::ST_IDLE: begin
        if (req.valid) begin
          state_next = swrl_pkg::ST_MOD;
        end
      end
      swrl_pkg::ST_MOD: begin
        // stale index from a larger ring: reduce before use
        if (idx_ext < n_use) begin
          div_req.start    = 1'b1;
          div_req.dividend = {window_ms, 32'd0};
          div_req.divisor  = swrl_pkg::CNT_W'(n_use);
          div_req.steps    = swrl_pkg::STEPS_WIDTH;
          state_next       = swrl_pkg::ST_DIVW;
        end
      end
      swrl_pkg::ST_DIVW: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = elapsed;
          div_req.divisor  = width_calc;
          div_req.steps    = swrl_pkg::STEPS_TIME;
          state_next       = swrl_pkg::ST_DIVE;
        end
      end
      swrl_pkg::ST_DIVE: begin
        if (div_rsp.done) begin
          state_next = (div_rsp.quotient != '0) ? swrl_pkg::ST_CLEAR : swrl_pkg::ST_SUM;
        end
      end
      swrl_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_wrap;
        if (clr_cnt == CW'(1)) begin
          state_next = swrl_pkg::ST_SUM;
        end
      end
      swrl_pkg::ST_SUM: begin
        mem_re = rd_ptr < n_use;
        if (rd_ptr == n_use && !rd_vld) begin
          state_next = swrl_pkg::ST_DECIDE;
        end
      end
      swrl_pkg::ST_DECIDE: begin
        // write-back is idempotent while the output register is busy
        if (grant && own != swrl_pkg::CNT_MAX) begin
          mem_we    = 1'b1;
          mem_wdata = own + 1'b1;
        end
        if (out_free) begin
          state_next = swrl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = swrl_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms     <= swrl_pkg::WINDOW_MS_RST;
      request_limit <= swrl_pkg::REQUEST_LIMIT_RST;
      split_num     <= swrl_pkg::SPLIT_NUM_RST;
      start_ms      <= '0;
      idx           <= '0;
      rd_vld        <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      // configuration writes
      if (cfg.valid) begin
        case (cfg.index)
          swrl_pkg::REG_WINDOW_MS:     window_ms     <= cfg.data;
          swrl_pkg::REG_REQUEST_LIMIT: request_limit <= cfg.data;
          swrl_pkg::REG_SPLIT_NUM:     split_num     <= cfg.data[swrl_pkg::SPLIT_W-1:0];
          default: ;
        endcase
      end

      // read data arrives the cycle after the read
      rd_vld <= mem_re;

      case (state)
        swrl_pkg::ST_IDLE: begin
          if (req.valid) begin
            now_q <= req.now_ms;
          end
        end
        swrl_pkg::ST_MOD: begin
          if (idx_ext >= n_use) begin
            idx <= IW'(idx_ext - n_use);
          end
        end
        swrl_pkg::ST_DIVE: begin
          if (div_rsp.done) begin
            rd_ptr  <= '0;
            sum     <= '0;
            clr_cnt <= slide;
            // start moves by whole slots: now minus the part-slot remainder
            if (div_rsp.quotient != '0) begin
              start_ms <= now_q - swrl_pkg::TIME_W'(div_rsp.remainder);
            end
          end
        end
        swrl_pkg::ST_CLEAR: begin
          idx     <= idx_wrap;
          clr_cnt <= clr_cnt - CW'(1);
        end
        swrl_pkg::ST_SUM: begin
          if (rd_ptr < n_use) begin
            rd_ptr  <= rd_ptr + CW'(1);
            rd_addr <= rd_ptr[IW-1:0];
          end
          if (rd_vld) begin
            sum <= sum + swrl_pkg::SUM_W'(mem_rdata);
            if (rd_addr == idx) begin
              own <= mem_rdata;
            end
          end
        end
        default: ;
      endcase

      // Output register: loaded on leaving DECIDE, emptied on handshake
      if (state == swrl_pkg::ST_DECIDE && out_free) begin
        res_valid   <= 1'b1;
        res_granted <= grant;
        res_count   <= sum_sat;
      end else if (res.valid && res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign req.ready        = state == swrl_pkg::ST_IDLE;
  assign cfg.ready        = 1'b1;
  assign res.valid        = res_valid;
  assign res.granted      = res_granted;
  assign res.window_count = res_count;

endmodule

>>> src/swrl_checker.sv
// Port-level checks for the rate limiter, bound to the top level.
// Depends on swrl_pkg and sliding_window_rate_limiter_top.
module swrl_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_ready,
  input logic                            res_valid,
  input logic                            res_ready,
  input logic                            granted,
  input logic [swrl_pkg::CNT_W-1:0]      window_count,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [swrl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [swrl_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [1:0]                 outstanding;
  logic [swrl_pkg::CNT_W-1:0] limit;
  logic                       in_acc;
  logic                       out_acc;

  assign in_acc  = req_valid && req_ready;
  assign out_acc = res_valid && res_ready;

  // Words accepted but not yet delivered, and a copy of the limit
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
      limit       <= swrl_pkg::REQUEST_LIMIT_RST;
    end else begin
      outstanding <= outstanding + {1'b0, in_acc} - {1'b0, out_acc};
      if (cfg_valid && cfg_ready && cfg_index == swrl_pkg::REG_REQUEST_LIMIT) begin
        limit <= cfg_data;
      end
    end
  end

  // A stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(granted) && $stable(window_count))
    else $error("result word changed while stalled");

  // No result without a request behind it
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> outstanding != 2'd0)
    else $error("result word with no request outstanding");

  // At most one request in work plus one result waiting
  a_depth: assert property (@(posedge clk) disable iff (rst)
    outstanding != 2'd3)
    else $error("more than two words in flight");

  // A grant only below the limit
  a_grant: assert property (@(posedge clk) disable iff (rst)
    res_valid && granted |-> window_count < limit)
    else $error("request granted at or above the limit");

endmodule

bind sliding_window_rate_limiter_top swrl_checker u_swrl_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .granted      (res.granted),
  .window_count (res.window_count),
  .cfg_valid    (cfg.valid),
  .cfg_ready    (cfg.ready),
  .cfg_index    (cfg.index),
  .cfg_data     (cfg.data)
);
